// ===== src/assert_macros.svh =====
// Assertion helpers used by mosl_merge. Each check is sampled on the rising
// clock edge and is switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AST_PROP(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== src/mosl_pkg.sv =====
package mosl_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int POS_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    localparam logic [1:0] KIND_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_APPEND_SECOND = 2'd1;
    localparam logic [1:0] KIND_COMPUTE       = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [32:0] median_doubled;
        logic [1:0]         status;
    } t_result;

endpackage

// ===== src/mosl_if.sv =====
interface mosl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mosl_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] median_doubled;
    logic [1:0]         status;

    modport source (output valid, output median_doubled, output status, input ready);
    modport sink   (input valid, input median_doubled, input status, output ready);
endinterface

// ===== src/mosl_merge.sv =====
`include "assert_macros.svh"

module mosl_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mosl_pkg::t_item   i_item,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output mosl_pkg::t_result o_res
);

    logic signed [31:0] r_mem_a [mosl_pkg::LIST_DEPTH];
    logic signed [31:0] r_mem_b [mosl_pkg::LIST_DEPTH];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;

    mosl_pkg::t_state r_state, n_state;

    logic [mosl_pkg::CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [mosl_pkg::CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic                       r_ovf, n_ovf;
    logic [mosl_pkg::CNT_W-1:0] r_i, n_i;
    logic [mosl_pkg::CNT_W-1:0] r_j, n_j;
    logic [mosl_pkg::POS_W-1:0] r_k, n_k;
    logic [mosl_pkg::POS_W-1:0] r_lo, n_lo;
    logic [mosl_pkg::POS_W-1:0] r_hi, n_hi;
    logic signed [32:0]         r_sum, n_sum;

    logic [mosl_pkg::POS_W-1:0] total;
    logic                       take_a;
    logic signed [31:0]         pick;
    logic                       wr_a;
    logic                       wr_b;
    logic                       compute;

    assign total   = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign compute = i_fire && (i_item.kind == mosl_pkg::KIND_COMPUTE);
    assign wr_a    = i_fire && (i_item.kind == mosl_pkg::KIND_APPEND_FIRST)
                     && (r_cnt_a < mosl_pkg::DEPTH_CNT);
    assign wr_b    = i_fire && (i_item.kind == mosl_pkg::KIND_APPEND_SECOND)
                     && (r_cnt_b < mosl_pkg::DEPTH_CNT);

    // The first list wins ties, and an exhausted list never wins.
    assign take_a = (r_i < r_cnt_a) && ((r_j >= r_cnt_b) || (r_rd_a <= r_rd_b));
    assign pick   = take_a ? r_rd_a : r_rd_b;

    // Both heads are read every cycle; the data is valid in the cycle after
    // the indexes settle, which is why each merge step spends LOAD then STEP.
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_cnt_a[mosl_pkg::ADDR_W-1:0]] <= i_item.value;
        end
        if (wr_b) begin
            r_mem_b[r_cnt_b[mosl_pkg::ADDR_W-1:0]] <= i_item.value;
        end
        r_rd_a <= r_mem_a[r_i[mosl_pkg::ADDR_W-1:0]];
        r_rd_b <= r_mem_b[r_j[mosl_pkg::ADDR_W-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mosl_pkg::ST_IDLE: begin
                if (compute) begin
                    n_state = (total == '0) ? mosl_pkg::ST_DONE : mosl_pkg::ST_LOAD;
                end
            end
            mosl_pkg::ST_LOAD: begin
                n_state = mosl_pkg::ST_STEP;
            end
            mosl_pkg::ST_STEP: begin
                n_state = (r_k == r_hi) ? mosl_pkg::ST_DONE : mosl_pkg::ST_LOAD;
            end
            mosl_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = mosl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mosl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_sum   = r_sum;
        unique case (r_state)
            mosl_pkg::ST_IDLE: begin
                case (i_item.kind)
                    mosl_pkg::KIND_APPEND_FIRST: begin
                        if (i_fire) begin
                            if (wr_a) begin
                                n_cnt_a = r_cnt_a + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    mosl_pkg::KIND_APPEND_SECOND: begin
                        if (i_fire) begin
                            if (wr_b) begin
                                n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_i  = '0;
                n_j  = '0;
                n_k  = '0;
                n_lo = (total - 1'b1) >> 1;
                n_hi = total >> 1;
            end
            mosl_pkg::ST_LOAD: begin
            end
            mosl_pkg::ST_STEP: begin
                if (take_a) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k == r_hi) begin
                    // For an odd total both middle positions are the same element.
                    n_sum = (r_lo == r_hi) ? {pick, 1'b0} : (r_sum + 33'(pick));
                end else if (r_k == r_lo) begin
                    n_sum = 33'(pick);
                end
            end
            mosl_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mosl_pkg::ST_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_sum <= n_sum;
    end

    assign o_idle      = (r_state == mosl_pkg::ST_IDLE);
    assign o_res_valid = (r_state == mosl_pkg::ST_DONE);

    always_comb begin
        if (total == '0) begin
            o_res.median_doubled = '0;
            o_res.status         = mosl_pkg::STATUS_EMPTY;
        end else begin
            o_res.median_doubled = r_sum;
            o_res.status         = r_ovf ? mosl_pkg::STATUS_OVERFLOW : mosl_pkg::STATUS_OK;
        end
    end

    `AST_NEVER(a_cnt_bound, i_clk, i_rst_n, (r_cnt_a > mosl_pkg::DEPTH_CNT) || (r_cnt_b > mosl_pkg::DEPTH_CNT))
    `AST_PROP(a_idx_bound, i_clk, i_rst_n, (r_state == mosl_pkg::ST_STEP) |-> ((r_i <= r_cnt_a) && (r_j <= r_cnt_b) && (r_k <= r_hi)))
    `AST_PROP(a_clear_after, i_clk, i_rst_n, (o_res_valid && i_res_ready) |=> ((r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf))
    `AST_PROP(a_walk_counts_hold, i_clk, i_rst_n, ((r_state == mosl_pkg::ST_LOAD) || (r_state == mosl_pkg::ST_STEP)) |=> ($stable(r_cnt_a) && $stable(r_cnt_b)))

endmodule

// ===== src/median_of_two_sorted_lists.sv =====
// Median of two sorted lists, reported as twice the median so it stays exact.
// Input channel i_item carries kind and value. Kind 0 appends value to the
// first list, kind 1 to the second, kind 2 asks for the median, kind 3 is
// dropped. Each list holds up to 1024 words; an append to a full list is
// lost and marks the next result with overflow status.
// Append words are taken back to back while the merge unit is idle.
// A compute word walks both lists in merge order on one compare unit fed by
// the two list memories. Each merge step passes through LOAD and then STEP
// because of the registered memory read, and the walk ends at the upper
// middle position; when both lists are empty the compute goes straight to
// DONE. The input is not ready while the walk runs.
// Output channel o_result carries median_doubled and status from an output
// register. While the receiver stalls, appends are still taken and a second
// compute still walks, but its result waits in the merge unit and blocks the
// input until the first result has been taken. Moving a result into the
// output register clears both lists and the overflow mark.
// Reset is synchronous and active low: both lists become empty and no
// result is pending. No memory clearing pass is needed.
module median_of_two_sorted_lists (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mosl_in_if.sink    i_item,
    mosl_out_if.source o_result
);

    mosl_pkg::t_item   item;
    mosl_pkg::t_result res;
    mosl_pkg::t_result r_out;
    logic              r_out_valid;
    logic              idle;
    logic              fire;
    logic              res_valid;
    logic              res_ready;

    assign item.kind  = i_item.kind;
    assign item.value = i_item.value;
    assign fire       = i_item.valid && idle;
    assign res_ready  = !r_out_valid || o_result.ready;

    mosl_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (item),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign i_item.ready            = idle;
    assign o_result.valid          = r_out_valid;
    assign o_result.median_doubled = r_out.median_doubled;
    assign o_result.status         = r_out.status;

endmodule

// ===== test/median_of_two_sorted_lists_tb.sv =====
`timescale 1ns / 1ps

module median_of_two_sorted_lists_tb;

    localparam logic [1:0]         KIND_UNUSED   = 2'd3;
    localparam logic signed [31:0] VAL_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX       = 32'sh7fff_ffff;
    localparam logic [31:0]        SIGN_FLIP     = 32'h8000_0000;
    localparam int                 SETTLE_CYCLES = 40;
    localparam int                 SIDE_FIRST    = 0;
    localparam int                 SIDE_SECOND   = 1;
    localparam int                 SIDE_NONE     = 2;

    // Keeps its own copy of both lists and predicts the doubled median of each
    // compute word; results are matched in order against that prediction.
    class median_board;
        logic signed [31:0] first_list[$];
        logic signed [31:0] second_list[$];
        bit                 overflow_seen;
        mosl_pkg::t_result  median_q[$];
        int                 n_words;
        int                 n_medians;
        int                 n_overflow;
        int                 n_empty;
        int                 n_fail;

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_fail++;
        endtask

        // Sum of the elements at the two middle positions of the merge walk.
        function logic signed [32:0] middle_sum();
            int                 n;
            int                 m;
            int                 lo_pos;
            int                 hi_pos;
            int                 i;
            int                 j;
            logic signed [31:0] pick;
            logic signed [32:0] sum;
            n      = first_list.size();
            m      = second_list.size();
            lo_pos = (n + m - 1) / 2;
            hi_pos = (n + m) / 2;
            i      = 0;
            j      = 0;
            sum    = '0;
            for (int k = 0; k <= hi_pos; k++) begin
                if (i < n && (j >= m || first_list[i] <= second_list[j])) begin
                    pick = first_list[i];
                    i++;
                end else begin
                    pick = second_list[j];
                    j++;
                end
                if (k == lo_pos) sum = sum + pick;
                if (k == hi_pos) sum = sum + pick;
            end
            return sum;
        endfunction

        function void note_item(logic [1:0] kind, logic signed [31:0] value);
            mosl_pkg::t_result want;
            n_words++;
            case (kind)
                mosl_pkg::KIND_APPEND_FIRST: begin
                    if (first_list.size() < mosl_pkg::LIST_DEPTH)
                        first_list.insert(first_list.size(), value);
                    else overflow_seen = 1'b1;
                end
                mosl_pkg::KIND_APPEND_SECOND: begin
                    if (second_list.size() < mosl_pkg::LIST_DEPTH)
                        second_list.insert(second_list.size(), value);
                    else overflow_seen = 1'b1;
                end
                mosl_pkg::KIND_COMPUTE: begin
                    if (first_list.size() + second_list.size() == 0) begin
                        want.median_doubled = '0;
                        want.status         = mosl_pkg::STATUS_EMPTY;
                    end else begin
                        want.median_doubled = middle_sum();
                        want.status         = overflow_seen ? mosl_pkg::STATUS_OVERFLOW
                                                            : mosl_pkg::STATUS_OK;
                    end
                    median_q.insert(median_q.size(), want);
                    first_list.delete();
                    second_list.delete();
                    overflow_seen = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task check_result(logic signed [32:0] got_median, logic [1:0] got_status);
            mosl_pkg::t_result want;
            if (median_q.size() == 0) begin
                report($sformatf("result with none pending: median_doubled=%0d status=%0d",
                                 got_median, got_status));
                return;
            end
            want = median_q.pop_front();
            n_medians++;
            if (got_median !== want.median_doubled)
                report($sformatf("median_doubled %0d, want %0d", got_median,
                                 want.median_doubled));
            if (got_status !== want.status)
                report($sformatf("status %0d, want %0d", got_status, want.status));
            if (want.status == mosl_pkg::STATUS_OVERFLOW) n_overflow++;
            if (want.status == mosl_pkg::STATUS_EMPTY) n_empty++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    mosl_in_if   item_if ();
    mosl_out_if  result_if ();
    median_board board = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    int          words_sent;

    median_of_two_sorted_lists uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready)
                board.check_result(result_if.median_doubled, result_if.status);
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [1:0] kind, input logic signed [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind  <= kind;
        item_if.value <= value;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        board.note_item(kind, value);
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (board.median_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value(int mode);
        logic signed [31:0] v;
        v = $urandom;
        if (mode == 1) begin
            // A narrow range gives duplicates and equal heads across the lists.
            v = 32'($urandom_range(0, 8));
            v = v - 4;
        end else if (mode == 2) begin
            case ($urandom_range(0, 4))
                0: v = VAL_MIN;
                1: v = VAL_MIN + 1;
                2: v = VAL_MAX - 1;
                3: v = VAL_MAX;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Values are held with the sign bit flipped so that an unsigned sort gives
    // ascending signed order.
    task automatic send_set(input int n1, input int n2, input bit sorted, input int mode);
        bit [31:0] a[$];
        bit [31:0] b[$];
        bit        take_first;
        repeat (n1) a.insert(a.size(), pick_value(mode) ^ SIGN_FLIP);
        repeat (n2) b.insert(b.size(), pick_value(mode) ^ SIGN_FLIP);
        if (sorted) begin
            a.sort();
            b.sort();
        end
        while (a.size() + b.size() > 0) begin
            if ($urandom_range(0, 39) == 0) send_word(KIND_UNUSED, $urandom);
            take_first = (b.size() == 0) || (a.size() != 0 && $urandom_range(0, 1) == 1);
            if (take_first)
                send_word(mosl_pkg::KIND_APPEND_FIRST, a.pop_front() ^ SIGN_FLIP);
            else
                send_word(mosl_pkg::KIND_APPEND_SECOND, b.pop_front() ^ SIGN_FLIP);
        end
        send_word(mosl_pkg::KIND_COMPUTE, $urandom);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input int target,
                             input int full_side);
        int start;
        int sel;
        int n1;
        int n2;
        start          = words_sent;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        // If full_side names a list, it is overfilled so that two appends are dropped.
        if (full_side == SIDE_FIRST)
            send_set(mosl_pkg::LIST_DEPTH + 2, $urandom_range(0, 5), 1'b1, 0);
        if (full_side == SIDE_SECOND)
            send_set($urandom_range(0, 5), mosl_pkg::LIST_DEPTH + 2, 1'b1, 0);
        while (words_sent - start < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                n1 = $urandom_range(0, 6);
                n2 = $urandom_range(0, 6);
            end else if (sel < 95) begin
                n1 = $urandom_range(0, 30);
                n2 = $urandom_range(0, 30);
            end else if (sel < 98) begin
                n1 = 0;
                n2 = $urandom_range(1, 12);
            end else begin
                n1 = $urandom_range(1, 12);
                n2 = 0;
            end
            send_set(n1, n2, $urandom_range(0, 9) != 0, $urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) drain();
        end
        drain();
    endtask

    initial begin
        item_if.valid  <= 1'b0;
        item_if.kind   <= mosl_pkg::KIND_APPEND_FIRST;
        item_if.value  <= '0;
        i_rst_n        <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        words_sent     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(mosl_pkg::KIND_COMPUTE, VAL_MAX);
        send_word(mosl_pkg::KIND_APPEND_FIRST, VAL_MIN);
        send_word(mosl_pkg::KIND_COMPUTE, '0);
        send_word(mosl_pkg::KIND_APPEND_SECOND, VAL_MAX);
        send_word(mosl_pkg::KIND_COMPUTE, VAL_MIN);
        send_word(mosl_pkg::KIND_APPEND_FIRST, VAL_MAX);
        send_word(mosl_pkg::KIND_APPEND_SECOND, VAL_MAX);
        send_word(mosl_pkg::KIND_COMPUTE, '0);
        send_word(mosl_pkg::KIND_APPEND_FIRST, VAL_MIN);
        send_word(mosl_pkg::KIND_APPEND_SECOND, VAL_MIN);
        send_word(mosl_pkg::KIND_COMPUTE, '0);
        send_word(mosl_pkg::KIND_APPEND_FIRST, 32'sd5);
        send_word(KIND_UNUSED, VAL_MAX);
        send_word(mosl_pkg::KIND_COMPUTE, '0);
        send_word(mosl_pkg::KIND_APPEND_FIRST, 32'sd1);
        send_word(mosl_pkg::KIND_APPEND_FIRST, 32'sd2);
        send_word(mosl_pkg::KIND_APPEND_SECOND, 32'sd1);
        send_word(mosl_pkg::KIND_COMPUTE, '0);
        // Unsorted lists: the walk order is 5, 3, 9, 1.
        send_word(mosl_pkg::KIND_APPEND_FIRST, 32'sd9);
        send_word(mosl_pkg::KIND_APPEND_FIRST, 32'sd1);
        send_word(mosl_pkg::KIND_APPEND_SECOND, 32'sd5);
        send_word(mosl_pkg::KIND_APPEND_SECOND, 32'sd3);
        send_word(mosl_pkg::KIND_COMPUTE, -32'sd1);
        drain();

        run_phase(10, 88, 1150, SIDE_FIRST);
        run_phase(88, 10, 350, SIDE_NONE);
        run_phase(0, 0, 400, SIDE_NONE);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d medians from %0d words, %0d of them with dropped appends",
                 board.n_medians, board.n_words, board.n_overflow);
        $display("and %0d on empty lists, under three sender and receiver idle mixes.",
                 board.n_empty);
        if (board.n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/mosl_pkg.sv
src/mosl_if.sv
src/mosl_merge.sv
src/median_of_two_sorted_lists.sv
test/median_of_two_sorted_lists_tb.sv
